// File: hdl/vxe_pkg.sv
// ----------------------------------------------------------------------------
// vxe_pkg
// Shared types and constants of the six-neighbour voxel erosion block.
// ----------------------------------------------------------------------------
package vxe_pkg;

    localparam int VOX_W = 8;

    typedef logic [VOX_W-1:0] t_label;

    // voxel labels
    localparam t_label LBL_BG  = 8'd1;
    localparam t_label LBL_TWO = 8'd2;
    localparam t_label LBL_FG  = 8'd255;

    // register index, taken from paddr[3:2]
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_WIDTH  = 2'd0;
    localparam t_reg_idx REG_HEIGHT = 2'd1;
    localparam t_reg_idx REG_DEPTH  = 2'd2;

    // per-item control that travels down the pipeline
    typedef struct packed {
        logic valid;
        logic has_res;
        logic x_first;
        logic x_last;
        logic y_first;
        logic y_last;
        logic z_edge;
        logic vol_last;
    } t_vox_ctl;

endpackage

// File: hdl/vxe_cfg.sv
// ----------------------------------------------------------------------------
// vxe_cfg
// Volume size registers with APB access; keeps clamped sizes and the
// derived plane geometry ready for the address logic.
// ----------------------------------------------------------------------------
module vxe_cfg #(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256,
    parameter int MAX_D = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [$clog2(MAX_W)-1:0]             o_w_last,
    output logic [$clog2(MAX_H)-1:0]             o_h_last,
    output logic [$clog2(MAX_D+1)-1:0]           o_depth,
    output logic [$clog2(2*MAX_W*MAX_H):0]       o_plane2,
    output logic [$clog2(2*MAX_W*MAX_H):0]       o_lead,
    output logic                                 o_h_one,
    output logic                                 o_restart
);
    import vxe_pkg::*;

    localparam int X_W  = $clog2(MAX_W);
    localparam int Y_W  = $clog2(MAX_H);
    localparam int Z_W  = $clog2(MAX_D + 1);
    localparam int WS_W = $clog2(MAX_W + 1);
    localparam int HS_W = $clog2(MAX_H + 1);
    localparam int A_W  = $clog2(2 * MAX_W * MAX_H);
    localparam int T_W  = A_W + 1;

    localparam int RST_W = (MAX_W < 256) ? MAX_W : 256;
    localparam int RST_H = (MAX_H < 256) ? MAX_H : 256;
    localparam int RST_D = (MAX_D < 256) ? MAX_D : 256;

    logic [8:0]          r_raw_w, n_raw_w;
    logic [8:0]          r_raw_h, n_raw_h;
    logic [10:0]         r_raw_d, n_raw_d;
    logic [X_W-1:0]      r_w_last;
    logic [Y_W-1:0]      r_h_last;
    logic [Z_W-1:0]      r_depth;
    logic [T_W-1:0]      r_plane2;
    logic [T_W-1:0]      r_lead;
    logic                r_h_one;

    logic                wr;
    logic [WS_W-1:0]     w_eff;
    logic [HS_W-1:0]     h_eff;
    logic [Z_W-1:0]      d_eff;
    logic [WS_W+HS_W-1:0] prod;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_comb begin
        n_raw_w = r_raw_w;
        n_raw_h = r_raw_h;
        n_raw_d = r_raw_d;
        if (wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  n_raw_w = pwdata[8:0];
                REG_HEIGHT: n_raw_h = pwdata[8:0];
                REG_DEPTH:  n_raw_d = pwdata[10:0];
                default: ;
            endcase
        end
    end

    assign o_restart = wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
                              paddr[3:2] == REG_DEPTH);

    // zero acts as one, oversize acts as the maximum
    assign w_eff = (n_raw_w == '0) ? WS_W'(1) :
                   ((32'(n_raw_w) > 32'(MAX_W)) ? WS_W'(MAX_W) : WS_W'(n_raw_w));
    assign h_eff = (n_raw_h == '0) ? HS_W'(1) :
                   ((32'(n_raw_h) > 32'(MAX_H)) ? HS_W'(MAX_H) : HS_W'(n_raw_h));
    assign d_eff = (n_raw_d == '0) ? Z_W'(1) :
                   ((32'(n_raw_d) > 32'(MAX_D)) ? Z_W'(MAX_D) : Z_W'(n_raw_d));
    assign prod  = w_eff * h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_w  <= 9'd256;
            r_raw_h  <= 9'd256;
            r_raw_d  <= 11'd256;
            r_w_last <= X_W'(RST_W - 1);
            r_h_last <= Y_W'(RST_H - 1);
            r_depth  <= Z_W'(RST_D);
            r_plane2 <= T_W'(2 * RST_W * RST_H);
            r_lead   <= T_W'(RST_W * RST_H + RST_W);
            r_h_one  <= (RST_H == 1);
        end else begin
            r_raw_w  <= n_raw_w;
            r_raw_h  <= n_raw_h;
            r_raw_d  <= n_raw_d;
            r_w_last <= X_W'(w_eff - WS_W'(1));
            r_h_last <= Y_W'(h_eff - HS_W'(1));
            r_depth  <= d_eff;
            r_plane2 <= T_W'({prod, 1'b0});
            r_lead   <= T_W'(prod) + T_W'(w_eff);
            r_h_one  <= (h_eff == HS_W'(1));
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {23'd0, r_raw_w};
            REG_HEIGHT: prdata = {23'd0, r_raw_h};
            REG_DEPTH:  prdata = {21'd0, r_raw_d};
            default:    prdata = '0;
        endcase
    end

    assign o_w_last = r_w_last;
    assign o_h_last = r_h_last;
    assign o_depth  = r_depth;
    assign o_plane2 = r_plane2;
    assign o_lead   = r_lead;
    assign o_h_one  = r_h_one;

endmodule

// File: hdl/vxe_plane_buf.sv
// ----------------------------------------------------------------------------
// vxe_plane_buf
// Raster position tracking and the two-plane label store. Each accepted
// transaction writes its label and reads the same slot two planes back plus
// the voxel one row below in the plane under evaluation.
// ----------------------------------------------------------------------------
module vxe_plane_buf #(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256,
    parameter int MAX_D = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_advance,
    input  vxe_pkg::t_label                      i_voxel,
    input  logic                                 i_restart,
    input  logic [$clog2(MAX_W)-1:0]             i_w_last,
    input  logic [$clog2(MAX_H)-1:0]             i_h_last,
    input  logic [$clog2(MAX_D+1)-1:0]           i_depth,
    input  logic [$clog2(2*MAX_W*MAX_H):0]       i_plane2,
    input  logic [$clog2(2*MAX_W*MAX_H):0]       i_lead,
    input  logic                                 i_h_one,
    output vxe_pkg::t_vox_ctl                    o_s1_ctl,
    output logic [$clog2(MAX_W)-1:0]             o_s1_x,
    output vxe_pkg::t_label                      o_s1_incoming,
    output vxe_pkg::t_label                      o_s1_older,
    output vxe_pkg::t_label                      o_s1_row_dn
);
    import vxe_pkg::*;

    localparam int X_W       = $clog2(MAX_W);
    localparam int Y_W       = $clog2(MAX_H);
    localparam int Z_W       = $clog2(MAX_D + 1);
    localparam int MEM_DEPTH = 2 * MAX_W * MAX_H;
    localparam int A_W       = $clog2(MEM_DEPTH);
    localparam int T_W       = A_W + 1;

    logic [X_W-1:0] r_pos_x, n_pos_x;
    logic [Y_W-1:0] r_pos_y, n_pos_y;
    logic [Z_W-1:0] r_pos_z, n_pos_z;
    logic [A_W-1:0] r_ptr,   n_ptr;

    t_label         r_plane_mem [MEM_DEPTH];

    t_vox_ctl       r_s1_ctl;
    logic [X_W-1:0] r_s1_x;
    t_label         r_s1_incoming;
    t_label         r_s1_older;
    t_label         r_s1_lead;

    t_vox_ctl       ctl;
    t_label         incoming;
    logic           x_last, y_last, z_at_d;
    logic [T_W-1:0] lead_sum;
    logic [T_W-1:0] ptr_inc;
    logic [A_W-1:0] rd_addr;

    assign x_last   = (r_pos_x == i_w_last);
    assign y_last   = (r_pos_y == i_h_last);
    assign z_at_d   = (r_pos_z == i_depth);
    // in the plane after the volume the item is a flush item and stores zero
    assign incoming = (r_pos_z < i_depth) ? i_voxel : '0;

    always_comb begin
        ctl          = '0;
        ctl.valid    = i_accept;
        ctl.has_res  = (r_pos_z != '0);
        ctl.x_first  = (r_pos_x == '0);
        ctl.x_last   = x_last;
        ctl.y_first  = (r_pos_y == '0);
        ctl.y_last   = y_last;
        ctl.z_edge   = (r_pos_z == Z_W'(1)) || z_at_d;
        ctl.vol_last = x_last && y_last && z_at_d;
    end

    // row below in the other bank; on the last row this wraps onto row 0
    // of the current plane, which primes the row buffer for the next plane
    assign lead_sum = {1'b0, r_ptr} + i_lead;
    assign rd_addr  = (lead_sum >= i_plane2) ? A_W'(lead_sum - i_plane2) : A_W'(lead_sum);
    assign ptr_inc  = {1'b0, r_ptr} + T_W'(1);

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_ptr   = r_ptr;
        if (i_restart) begin
            n_pos_x = '0;
            n_pos_y = '0;
            n_pos_z = '0;
            n_ptr   = '0;
        end else if (i_accept) begin
            n_ptr = (ptr_inc == i_plane2) ? '0 : A_W'(ptr_inc);
            if (x_last) begin
                n_pos_x = '0;
                if (y_last) begin
                    n_pos_y = '0;
                    if (z_at_d) begin
                        n_pos_z = '0;
                        n_ptr   = '0;
                    end else begin
                        n_pos_z = r_pos_z + Z_W'(1);
                    end
                end else begin
                    n_pos_y = r_pos_y + Y_W'(1);
                end
            end else begin
                n_pos_x = r_pos_x + X_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_ptr    <= '0;
            r_s1_ctl <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_ptr   <= n_ptr;
            if (i_advance) begin
                r_s1_ctl <= ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_x        <= r_pos_x;
            r_s1_incoming <= incoming;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_plane_mem[r_ptr] <= incoming;
        end
        if (i_advance) begin
            r_s1_older <= r_plane_mem[r_ptr];
            r_s1_lead  <= r_plane_mem[rd_addr];
        end
    end

    assign o_s1_ctl      = r_s1_ctl;
    assign o_s1_x        = r_s1_x;
    assign o_s1_incoming = r_s1_incoming;
    assign o_s1_older    = r_s1_older;
    // single-row planes: the row below is the label arriving now
    assign o_s1_row_dn   = i_h_one ? r_s1_incoming : r_s1_lead;

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_x <= i_w_last)
        else $error("column counter beyond row width");

    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_z <= i_depth)
        else $error("plane counter beyond flush plane");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ptr} < i_plane2)
        else $error("plane store pointer outside two planes");

    a_vol_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && ctl.vol_last |=>
            r_pos_x == '0 && r_pos_y == '0 && r_pos_z == '0 && r_ptr == '0)
        else $error("volume did not restart after last flush transaction");

endmodule

// File: hdl/vxe_window.sv
// ----------------------------------------------------------------------------
// vxe_window
// Row buffers that complete the six-neighbour window, the erosion decision
// and the output register.
// ----------------------------------------------------------------------------
module vxe_window #(
    parameter int MAX_W = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  vxe_pkg::t_vox_ctl           i_s1_ctl,
    input  logic [$clog2(MAX_W)-1:0]    i_s1_x,
    input  vxe_pkg::t_label             i_s1_incoming,
    input  vxe_pkg::t_label             i_s1_older,
    input  vxe_pkg::t_label             i_s1_row_dn,
    output logic                        o_out_valid,
    output vxe_pkg::t_label             o_voxel,
    output logic                        o_vol_last
);
    import vxe_pkg::*;

    localparam int X_W = $clog2(MAX_W);

    // row_a: stream of row-below labels, read back one row later as the
    // center row; row_b: center labels, read back one row later as row above
    t_label         r_row_a [MAX_W];
    t_label         r_row_b [MAX_W];

    t_vox_ctl       r_s2_ctl;
    logic [X_W-1:0] r_s2_x;
    t_label         r_s2_c;
    t_label         r_s2_right;
    t_label         r_s2_up;
    t_label         r_s2_dn;
    t_label         r_s2_incoming;
    t_label         r_s2_older;
    t_label         r_prev_c;

    logic           r_out_valid;
    t_label         r_out_voxel;
    logic           r_out_last;

    logic [X_W-1:0] x_nxt;
    logic           on_edge;
    logic           near_bg;
    t_label         res;

    assign x_nxt = (i_s1_x == X_W'(MAX_W - 1)) ? i_s1_x : i_s1_x + X_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s2_c     <= r_row_a[i_s1_x];
            r_s2_right <= r_row_a[x_nxt];
            if (i_s1_ctl.valid) begin
                r_row_a[i_s1_x] <= i_s1_row_dn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s2_up <= r_row_b[i_s1_x];
            if (r_s2_ctl.valid) begin
                r_row_b[r_s2_x] <= r_s2_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s2_x        <= i_s1_x;
            r_s2_dn       <= i_s1_row_dn;
            r_s2_incoming <= i_s1_incoming;
            r_s2_older    <= i_s1_older;
            if (r_s2_ctl.valid) begin
                r_prev_c <= r_s2_c;
            end
            r_out_voxel <= res;
            r_out_last  <= r_s2_ctl.vol_last;
        end
    end

    always_comb begin
        on_edge = r_s2_ctl.x_first || r_s2_ctl.x_last || r_s2_ctl.y_first ||
                  r_s2_ctl.y_last  || r_s2_ctl.z_edge;
        near_bg = (r_prev_c <= LBL_BG) || (r_s2_right <= LBL_BG) ||
                  (r_s2_up <= LBL_BG)  || (r_s2_dn <= LBL_BG)    ||
                  (r_s2_older <= LBL_BG) || (r_s2_incoming <= LBL_BG);
        res = r_s2_c;
        if (r_s2_c == LBL_FG) begin
            if (on_edge || near_bg) begin
                res = LBL_BG;
            end
        end else if (r_s2_c == LBL_TWO) begin
            res = LBL_BG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_s2_ctl    <= i_s1_ctl;
            r_out_valid <= r_s2_ctl.valid && r_s2_ctl.has_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_voxel     = r_out_voxel;
    assign o_vol_last  = r_out_last;

endmodule

// File: hdl/voxel_erode_6_neighbour.sv
// ----------------------------------------------------------------------------
// voxel_erode_6_neighbour
// Six-neighbour erosion of a labelled voxel volume streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Voxels enter on the s_axis channel, x fastest, then y, then z. After the
//   volume the host sends one more plane of transactions; these are treated
//   as flush items by position, whatever their tuser bit. Each transaction
//   from the second plane on returns one eroded label on m_axis, for the
//   voxel one plane earlier; tlast marks the final voxel of the volume.
//   Sizes are set through the APB port while the stream is idle; any size
//   write starts a new volume.
// Timing:
//   One transaction per cycle unless a waiting result stalls the pipeline.
//   A result is valid once the transaction causing it has passed the plane
//   store read at the accepting edge, the row buffer read that follows and
//   the load of the output register.
// Reset and stall:
//   Reset sets the sizes to 256 and starts a new volume. The plane store
//   needs no clearing: every slot that decides a result is written within
//   the volume before it is read. While a result waits with m_axis_tready
//   low the whole pipeline holds and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module voxel_erode_6_neighbour #(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256,
    parameter int MAX_D = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] voxel_in
    input  logic        s_axis_tuser,   // [0] flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] voxel_out
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vxe_pkg::*;

    localparam int X_W = $clog2(MAX_W);
    localparam int Y_W = $clog2(MAX_H);
    localparam int Z_W = $clog2(MAX_D + 1);
    localparam int T_W = $clog2(2 * MAX_W * MAX_H) + 1;

    logic           advance;
    logic           accept;
    logic [X_W-1:0] w_last;
    logic [Y_W-1:0] h_last;
    logic [Z_W-1:0] depth;
    logic [T_W-1:0] plane2;
    logic [T_W-1:0] lead;
    logic           h_one;
    logic           restart;

    t_vox_ctl       s1_ctl;
    logic [X_W-1:0] s1_x;
    t_label         s1_incoming;
    t_label         s1_older;
    t_label         s1_row_dn;
    logic           out_valid;

    // the item role comes from its position, so the flush flag is not needed
    assign advance       = !out_valid || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign m_axis_tvalid = out_valid;

    vxe_cfg #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H),
        .MAX_D (MAX_D)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_w_last  (w_last),
        .o_h_last  (h_last),
        .o_depth   (depth),
        .o_plane2  (plane2),
        .o_lead    (lead),
        .o_h_one   (h_one),
        .o_restart (restart)
    );

    vxe_plane_buf #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H),
        .MAX_D (MAX_D)
    ) u_plane_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_advance     (advance),
        .i_voxel       (s_axis_tdata),
        .i_restart     (restart),
        .i_w_last      (w_last),
        .i_h_last      (h_last),
        .i_depth       (depth),
        .i_plane2      (plane2),
        .i_lead        (lead),
        .i_h_one       (h_one),
        .o_s1_ctl      (s1_ctl),
        .o_s1_x        (s1_x),
        .o_s1_incoming (s1_incoming),
        .o_s1_older    (s1_older),
        .o_s1_row_dn   (s1_row_dn)
    );

    vxe_window #(
        .MAX_W (MAX_W)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_s1_ctl      (s1_ctl),
        .i_s1_x        (s1_x),
        .i_s1_incoming (s1_incoming),
        .i_s1_older    (s1_older),
        .i_s1_row_dn   (s1_row_dn),
        .o_out_valid   (out_valid),
        .o_voxel       (m_axis_tdata),
        .o_vol_last    (m_axis_tlast)
    );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the six-neighbour voxel erosion block. Voxels are
// streamed in raster order with random gaps while the result side stalls at
// random. Every accepted transaction goes through a local erosion predictor.
// Each result is compared with the oldest expected label and end-of-volume
// flag. Sizes are changed over APB between volumes and read back.
// ----------------------------------------------------------------------------
module tb;

    import vxe_pkg::*;

    localparam int MAX_W     = 256;
    localparam int MAX_H     = 256;
    localparam int MAX_D     = 1024;
    localparam int DRAIN_CYC = 8;
    localparam int RAND_GOAL = 250;
    localparam int N_ROWS    = 15;

    // no register behind this index
    localparam t_reg_idx REG_SPARE = 2'd3;

    typedef struct packed {
        t_label label;
        logic   last;
    } t_eroded;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_TYPED
    } t_exp_kind;

    typedef struct packed {
        t_label    vox;
        logic      flush;
        t_exp_kind kind;
        t_eroded   res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] voxel_in
    logic        s_axis_tuser = 1'b0;   // [0] flush
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] voxel_out
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    voxel_erode_6_neighbour dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #6400000;
        $display("FAILURE");
        $finish;
    end

    // erosion predictor state
    bit [7:0]    plane_mem [0:2*MAX_W*MAX_H-1];
    int unsigned size_w = 256;
    int unsigned size_h = 256;
    int unsigned size_d = 256;
    int unsigned at_x, at_y, at_z;

    t_eroded eroded_q [$];
    int      err_cnt = 0;
    bit      tx_calm = 1'b0;
    int      rx_hold = 0;
    int      rx_calm = 0;

    const t_dir_row dir_rows [N_ROWS] = '{
        '{LBL_FG,  1'b0, EXP_NONE,  '{8'd0,   1'b0}},
        '{8'd0,    1'b1, EXP_TYPED, '{LBL_BG, 1'b0}},
        '{LBL_BG,  1'b0, EXP_TYPED, '{8'd0,   1'b0}},
        '{LBL_TWO, 1'b0, EXP_TYPED, '{LBL_BG, 1'b0}},
        '{8'd3,    1'b0, EXP_TYPED, '{LBL_BG, 1'b0}},
        '{8'd254,  1'b0, EXP_TYPED, '{8'd3,   1'b0}},
        '{8'd128,  1'b0, EXP_TYPED, '{8'd254, 1'b0}},
        '{8'd127,  1'b0, EXP_TYPED, '{8'd128, 1'b0}},
        '{8'h55,   1'b0, EXP_TYPED, '{8'd127, 1'b0}},
        '{8'hAA,   1'b0, EXP_TYPED, '{8'h55,  1'b0}},
        '{LBL_FG,  1'b1, EXP_TYPED, '{8'hAA,  1'b0}},
        '{8'd0,    1'b0, EXP_TYPED, '{LBL_BG, 1'b0}},
        '{8'h77,   1'b1, EXP_TYPED, '{8'd0,   1'b1}},
        '{LBL_FG,  1'b1, EXP_NONE,  '{8'd0,   1'b0}},
        '{LBL_BG,  1'b0, EXP_TYPED, '{LBL_BG, 1'b0}}
    };

    function automatic int unsigned eff_size(int unsigned v, int unsigned m);
        if (v == 0) return 1;
        if (v > m) return m;
        return v;
    endfunction

    task automatic erode_predict(input t_label vin, output bit has, output t_eroded res);
        int unsigned w, h, d, addr, cur, prv, zo, nx, ny, nz;
        t_label incoming, older, c;
        bit border;
        w = eff_size(size_w, MAX_W);
        h = eff_size(size_h, MAX_H);
        d = eff_size(size_d, MAX_D);
        addr = at_y * w + at_x;
        cur = (at_z % 2) * w * h;
        prv = ((at_z + 1) % 2) * w * h;
        // the plane after the volume stores zeros
        incoming = (at_z < d) ? vin : 8'd0;
        older = plane_mem[cur + addr];
        plane_mem[cur + addr] = incoming;
        has = 1'b0;
        res = '0;
        if (at_z >= 1) begin
            zo = at_z - 1;
            c = plane_mem[prv + addr];
            res.label = c;
            if (c == LBL_FG) begin
                border = at_x == 0 || at_y == 0 || zo == 0 ||
                         at_x == w - 1 || at_y == h - 1 || zo == d - 1;
                if (border)
                    res.label = LBL_BG;
                else if (plane_mem[prv + addr - 1] <= LBL_BG ||
                         plane_mem[prv + addr + 1] <= LBL_BG ||
                         plane_mem[prv + addr - w] <= LBL_BG ||
                         plane_mem[prv + addr + w] <= LBL_BG ||
                         older <= LBL_BG || incoming <= LBL_BG)
                    res.label = LBL_BG;
            end else if (c == LBL_TWO) begin
                res.label = LBL_BG;
            end
            res.last = (at_x == w - 1 && at_y == h - 1 && zo == d - 1);
            has = 1'b1;
        end
        nx = at_x + 1;
        ny = at_y;
        nz = at_z;
        if (nx >= w) begin
            nx = 0;
            ny++;
            if (ny >= h) begin
                ny = 0;
                nz++;
            end
        end
        if (nz > d) begin
            at_x = 0;
            at_y = 0;
            at_z = 0;
        end else begin
            at_x = nx;
            at_y = ny;
            at_z = nz;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_label pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return LBL_FG;
        if (r < 70) return LBL_BG;
        if (r < 80) return 8'd0;
        if (r < 85) return LBL_TWO;
        return t_label'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 5);
        if (r < 92) return 0;
        return $urandom_range(6, 10);
    endfunction

    // starts and ends right after a rising edge
    task automatic apb_xfer(input bit wr, input t_reg_idx idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== want) begin
            $display("%0t register %0d read expected %0d got %0d", $time, idx, want, got);
            err_cnt++;
        end
    endtask

    task automatic write_size(input t_reg_idx idx, input int unsigned val);
        logic [31:0] mask, wdata, dummy;
        mask = (idx == REG_DEPTH) ? 32'h7FF : 32'h1FF;
        // junk above the field must be dropped
        wdata = ($urandom() & ~mask) | (val & mask);
        apb_xfer(1'b1, idx, wdata, dummy);
        if (idx != REG_SPARE) begin
            case (idx)
                REG_WIDTH:  size_w = val & mask;
                REG_HEIGHT: size_h = val & mask;
                default:    size_d = val & mask;
            endcase
            at_x = 0;
            at_y = 0;
            at_z = 0;
            check_reg(idx, val & mask);
        end
    endtask

    task automatic send_voxel(input t_label v, input logic f, input t_exp_kind kind,
                              input t_eroded typed);
        int gap;
        bit has;
        t_eroded res;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        erode_predict(v, has, res);
        if (kind == EXP_TYPED)
            eroded_q.insert(eroded_q.size(), typed);
        else if (kind == EXP_MODEL && has)
            eroded_q.insert(eroded_q.size(), res);
    endtask

    // a result can still be in flight after an item that yields none
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (eroded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // next item by position: voxel of the volume or part of the flush plane
    task automatic send_random_item();
        if (at_z >= eff_size(size_d, MAX_D))
            send_voxel(t_label'($urandom_range(0, 255)), $urandom_range(0, 7) != 0,
                       EXP_MODEL, '0);
        else
            send_voxel(pick_label(), $urandom_range(0, 15) == 0, EXP_MODEL, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (eroded_q.size() == 0) begin
                $display("%0t unexpected transaction: expected none, got label %0d last %0d",
                         $time, m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                if (m_axis_tdata !== eroded_q[0].label) begin
                    $display("%0t voxel_out expected %0d got %0d",
                             $time, eroded_q[0].label, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tlast !== eroded_q[0].last) begin
                    $display("%0t vol_last expected %0d got %0d",
                             $time, eroded_q[0].last, m_axis_tlast);
                    err_cnt++;
                end
                eroded_q.delete(0);
            end
        end
        if (rx_calm > 0) begin
            rx_calm--;
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 999)) inside
                [0:2]: begin
                    rx_calm = $urandom_range(100, 300);
                    m_axis_tready <= 1'b1;
                end
                [3:699]: m_axis_tready <= 1'b1;
                [700:959]: begin
                    rx_hold = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end
                default: begin
                    rx_hold = $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
            endcase
        end
    end

    initial begin
        int unsigned n_vol, n_items, rand_items, pause_at;
        bit first_phase;
        rand_items  = 0;
        first_phase = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_reg(REG_WIDTH, 32'd256);
        check_reg(REG_HEIGHT, 32'd256);
        check_reg(REG_DEPTH, 32'd256);

        // one voxel per plane: every voxel is on the border
        write_size(REG_WIDTH, 0);
        write_size(REG_HEIGHT, 0);
        write_size(REG_DEPTH, 12);
        foreach (dir_rows[i])
            send_voxel(dir_rows[i].vox, dir_rows[i].flush, dir_rows[i].kind, dir_rows[i].res);
        wait_drained();

        // widest row, one plane; a write to the spare index must not restart
        write_size(REG_WIDTH, 511);
        write_size(REG_HEIGHT, 0);
        write_size(REG_DEPTH, 0);
        repeat (MAX_W) send_random_item();
        wait_drained();
        write_size(REG_SPARE, $urandom_range(0, 511));
        repeat (MAX_W) send_random_item();
        wait_drained();

        // tallest column
        write_size(REG_WIDTH, 1);
        write_size(REG_HEIGHT, 511);
        write_size(REG_DEPTH, 1);
        repeat (2 * MAX_H) send_random_item();
        wait_drained();

        // deepest volume, cut short by the next size write
        write_size(REG_WIDTH, 0);
        write_size(REG_HEIGHT, 0);
        write_size(REG_DEPTH, 2047);
        repeat (40) send_random_item();
        wait_drained();

        while (rand_items < RAND_GOAL) begin
            if ($urandom_range(0, 3) != 0) write_size(REG_WIDTH, pick_dim());
            if ($urandom_range(0, 3) != 0) write_size(REG_HEIGHT, pick_dim());
            if ($urandom_range(0, 3) != 0) write_size(REG_DEPTH, pick_dim());
            n_vol = eff_size(size_w, MAX_W) * eff_size(size_h, MAX_H) *
                    (eff_size(size_d, MAX_D) + 1);
            case ($urandom_range(0, 99)) inside
                [0:74]:  n_items = n_vol;
                [75:87]: n_items = $urandom_range(1, n_vol);
                default: n_items = n_vol + $urandom_range(1, n_vol);
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            pause_at = (first_phase || $urandom_range(0, 5) == 0) ?
                       $urandom_range(0, n_items - 1) : n_items;
            first_phase = 1'b0;
            for (int unsigned i = 0; i < n_items; i++) begin
                if (i == pause_at) begin
                    // hold the input until the output side has caught up
                    s_axis_tvalid <= 1'b0;
                    while (eroded_q.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
                send_random_item();
            end
            rand_items += n_items;
            wait_drained();
        end

        repeat (4 * DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
